[hdl/combination_set_filter_defines.svh]
// Assertion macros used by the combination set filter checker.
`ifndef COMBINATION_SET_FILTER_DEFINES_SVH
`define COMBINATION_SET_FILTER_DEFINES_SVH

// Checked at every rising edge, suspended while reset is asserted.
`define CSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset cycles included.
`define CSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/csf_pkg.sv]
// Shared types and constants of the combination set filter.
`default_nettype none
package csf_pkg;

  localparam int MAX_ITEMS   = 16;
  localparam int MAX_SET_DEF = 1024;
  localparam int MASK_W      = 16;
  localparam int POS_W       = 5;
  localparam int CNT_FIELD_W = 11;

  localparam logic [1:0] OP_REBUILD = 2'd0;
  localparam logic [1:0] OP_FILTER  = 2'd1;
  localparam logic [1:0] OP_COUNT   = 2'd2;
  localparam logic [1:0] OP_RANK    = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_RANK = 2'd1;
  localparam logic [1:0] STAT_SET  = 2'd2;

  localparam logic REG_ITEM_COUNT   = 1'b0;
  localparam logic REG_CHOSEN_COUNT = 1'b1;

  typedef struct packed {
    logic              live;
    logic [MASK_W-1:0] mask;
  } cell_t;

  typedef struct packed {
    logic start;
    logic adv;
    logic stop;
  } gen_ctl_t;

endpackage
`default_nettype wire

[hdl/csf_cell.sv]
// One cell of the circulating combination chain: a mask and its live bit.
`default_nettype none
module csf_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  csf_pkg::cell_t d,
  output csf_pkg::cell_t q
);
  import csf_pkg::*;

  logic              live_r;
  logic [MASK_W-1:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else if (shift) begin
      live_r <= d.live;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      mask_r <= d.mask;
    end
  end

  assign q = '{live: live_r, mask: mask_r};
endmodule
`default_nettype wire

[hdl/csf_combgen.sv]
// Generator that steps through K-of-N masks in lexicographic order.
`default_nettype none
module csf_combgen (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csf_pkg::gen_ctl_t           ctl,
  input  logic [4:0]                  n,
  input  logic [4:0]                  k,
  output logic                        valid,
  output logic [csf_pkg::MASK_W-1:0]  mask
);
  import csf_pkg::*;

  logic [POS_W-1:0] pos_r   [MAX_ITEMS];
  logic [POS_W-1:0] pos_nxt [MAX_ITEMS];
  logic             valid_r, valid_nxt;
  logic [3:0]       sel;
  logic             found;
  logic [5:0]       limit;

  // Mask of the current positions; only the first K positions count.
  always_comb begin
    mask = '0;
    for (int j = 0; j < MAX_ITEMS; j++) begin
      if (5'(j) < k) begin
        mask[pos_r[j][3:0]] = 1'b1;
      end
    end
  end

  // The rightmost position that has not yet reached its ceiling moves up.
  always_comb begin
    found = 1'b0;
    sel   = '0;
    limit = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      limit = 6'(n) - 6'(k) + 6'(i);
      if (5'(i) < k && 6'(pos_r[i]) != limit) begin
        found = 1'b1;
        sel   = 4'(i);
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    if (ctl.start) begin
      for (int j = 0; j < MAX_ITEMS; j++) begin
        pos_nxt[j] = POS_W'(j);
      end
      valid_nxt = (k <= n) && (n <= 5'(MAX_ITEMS));
    end else if (ctl.stop) begin
      valid_nxt = 1'b0;
    end else if (ctl.adv) begin
      if (found) begin
        for (int j = 0; j < MAX_ITEMS; j++) begin
          if (4'(j) >= sel) begin
            pos_nxt[j] = pos_r[sel] + POS_W'(j) - POS_W'(sel) + POS_W'(1);
          end
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

  assign valid = valid_r;
endmodule
`default_nettype wire

[hdl/combination_set_filter.sv]
// Top level of the combination set filter: cell chain, generator and control.
//
// The set of K-of-N masks lives in a ring of MAX_SET cells that rotates one
// place per cycle while a turn is in progress and holds still otherwise;
// every operation makes one full turn of the ring, so each entry passes the
// head once and comes back to its own place. A filter, count or rank lookup
// loads its result into the output register after the turn, once that
// register holds no untaken result. A rebuild feeds freshly generated masks
// into the tail during the turn, unless the set would exceed MAX_SET
// entries: then a second turn clears every live bit before the result is
// loaded. A new item is taken only once the previous one has finished and
// loaded its result; a finished result waits in the output register while
// the next item starts.
// The configuration registers (item count at byte 0, chosen count at byte
// 4) may be written only while no item is in progress.
`default_nettype none
module combination_set_filter #(
  parameter int MAX_SET = csf_pkg::MAX_SET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_test_mask,
  input  logic        in_want,
  input  logic [9:0]  in_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_live_count,
  output logic [10:0] out_hit_count,
  output logic        out_informative,
  output logic [15:0] out_found_mask,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import csf_pkg::*;

  localparam int AW   = $clog2(MAX_SET);
  localparam int CW   = $clog2(MAX_SET + 1);
  localparam int CMPW = (CW > 10) ? CW : 10;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Configuration registers.
  logic [4:0] n_r, k_r;

  // Control and operand registers.
  logic [1:0]        state_r, state_nxt;
  logic [1:0]        op_r;
  logic [MASK_W-1:0] test_r;
  logic              want_r;
  logic [9:0]        rank_r;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     live_total_r, live_total_nxt;
  logic [MASK_W-1:0] found_r, found_nxt;
  logic              fail_r, fail_nxt;
  logic              bad_r;

  // Output register.
  logic              out_valid_r;
  logic [10:0]       out_live_r, out_hit_r;
  logic              out_inf_r;
  logic [MASK_W-1:0] out_found_r;
  logic [1:0]        out_status_r;
  logic              out_load;
  logic [10:0]       res_live, res_hit;
  logic              res_inf;
  logic [MASK_W-1:0] res_found;
  logic [1:0]        res_status;

  // Ring and generator.
  cell_t             chain [MAX_SET];
  cell_t             head, tail_in;
  logic              shift;
  logic              hit;
  gen_ctl_t          gen_ctl;
  logic              gen_valid;
  logic [MASK_W-1:0] gen_mask;
  logic [CMPW-1:0]   cnt_x, rank_x, live_x;

  logic in_xfer, cfg_wr;

  assign in_xfer = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register reads return the stored counts.
  always_comb begin
    if (paddr[2] == REG_CHOSEN_COUNT) begin
      prdata = {27'd0, k_r};
    end else begin
      prdata = {27'd0, n_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= 5'd8;
      k_r <= 5'd3;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ITEM_COUNT) begin
        n_r <= pwdata[4:0];
      end else begin
        k_r <= pwdata[4:0];
      end
    end
  end

  // The ring rotates toward cell zero; the head's processed entry re-enters
  // at the far end, so after MAX_SET shifts every entry is back in place.
  assign shift = (state_r == ST_SCAN) || (state_r == ST_CLEAR);
  assign head  = chain[0];

  for (genvar g = 0; g < MAX_SET; g++) begin : g_cell
    if (g == MAX_SET - 1) begin : g_last
      csf_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d     (tail_in),
        .q     (chain[g])
      );
    end else begin : g_mid
      csf_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d     (chain[g+1]),
        .q     (chain[g])
      );
    end
  end

  csf_combgen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (gen_ctl),
    .n     (n_r),
    .k     (k_r),
    .valid (gen_valid),
    .mask  (gen_mask)
  );

  assign hit    = |(head.mask & test_r);
  assign cnt_x  = CMPW'(cnt_r);
  assign rank_x = CMPW'(rank_r);
  assign live_x = CMPW'(live_total_r);

  // Head processing and sequencing.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    fail_nxt       = fail_r;
    live_total_nxt = live_total_r;
    tail_in        = head;
    gen_ctl        = '{start: 1'b0, adv: 1'b0, stop: 1'b0};
    out_load       = 1'b0;
    res_live       = 11'(live_total_r);
    res_hit        = '0;
    res_inf        = 1'b0;
    res_found      = '0;
    res_status     = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          found_nxt = '0;
          fail_nxt  = 1'b0;
          gen_ctl.start = (in_operation == OP_REBUILD);
        end
      end
      ST_SCAN: begin
        case (op_r)
          OP_REBUILD: begin
            // Slots past the last combination are marked dead.
            tail_in = gen_valid ? cell_t'{live: 1'b1, mask: gen_mask}
                                : cell_t'{live: 1'b0, mask: head.mask};
            if (gen_valid) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            gen_ctl.adv = gen_valid;
          end
          OP_FILTER: begin
            tail_in.live = head.live && (hit == want_r);
            if (head.live && (hit == want_r)) begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          OP_COUNT: begin
            if (head.live && hit) begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          default: begin
            // Rank lookup: the count of live entries seen so far matches the
            // asked rank exactly once, and only if the rank is in range.
            if (head.live) begin
              cnt_nxt = cnt_r + CW'(1);
              if (cnt_x == rank_x) begin
                found_nxt = head.mask;
              end
            end
          end
        endcase
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(MAX_SET - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_CLEAR: begin
        tail_in.live = 1'b0;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(MAX_SET - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      default: begin
        if (op_r == OP_REBUILD && gen_valid) begin
          // More combinations than cells: wipe the ring in a second turn.
          state_nxt    = ST_CLEAR;
          idx_nxt      = '0;
          fail_nxt     = 1'b1;
          gen_ctl.stop = 1'b1;
        end else if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          case (op_r)
            OP_REBUILD: begin
              if (fail_r || bad_r) begin
                live_total_nxt = '0;
                res_status     = STAT_SET;
              end else begin
                live_total_nxt = cnt_r;
              end
              res_live = 11'(live_total_nxt);
            end
            OP_FILTER: begin
              live_total_nxt = cnt_r;
              res_live       = 11'(cnt_r);
            end
            OP_COUNT: begin
              res_hit = 11'(cnt_r);
              res_inf = (cnt_r != '0) && (cnt_r < live_total_r);
            end
            default: begin
              if (rank_x >= live_x) begin
                res_status = STAT_RANK;
              end else begin
                res_found = found_r;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      cnt_r        <= '0;
      fail_r       <= 1'b0;
      live_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      fail_r       <= fail_nxt;
      live_total_r <= live_total_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand and result payload registers.
  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    if (in_xfer) begin
      op_r   <= in_operation;
      test_r <= in_test_mask;
      want_r <= in_want;
      rank_r <= in_rank;
      bad_r  <= (k_r > n_r) || (n_r > 5'(MAX_ITEMS));
    end
    if (out_load) begin
      out_live_r   <= res_live;
      out_hit_r    <= res_hit;
      out_inf_r    <= res_inf;
      out_found_r  <= res_found;
      out_status_r <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_live_count  = out_live_r;
  assign out_hit_count   = out_hit_r;
  assign out_informative = out_inf_r;
  assign out_found_mask  = out_found_r;
  assign out_status      = out_status_r;
endmodule
`default_nettype wire

[hdl/csf_checker.sv]
// Port-level checks of the combination set filter, bound to the top level.
`default_nettype none
`include "combination_set_filter_defines.svh"
module csf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] out_live_count,
  input logic [10:0] out_hit_count,
  input logic        out_informative,
  input logic [15:0] out_found_mask,
  input logic [1:0]  out_status
);
  import csf_pkg::*;

  `CSF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped before transfer")
  `CSF_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready, "second item taken while busy")
  `CSF_ASSERT(a_status_code, out_valid |-> out_status != 2'd3, "undefined status code")
  `CSF_ASSERT(a_inform, out_valid && out_informative |-> out_hit_count != 11'd0 && out_hit_count < out_live_count, "informative flag without partial hits")
  `CSF_ASSERT(a_rank_miss, out_valid && out_status == STAT_RANK |-> out_found_mask == 16'd0, "mask reported for a missing rank")
endmodule

bind combination_set_filter csf_checker u_csf_checker (.*);
`default_nettype wire
